[hdl/gbt_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbt_pkg
// shared types, constants and register indexes of the gradient/bevel texture
// ---------------------------------------------------------------------------
package gbt_pkg;

   localparam int MAX_SIDE = 4096;
   localparam int SIDE_W   = $clog2(MAX_SIDE) + 1;
   localparam int COORD_W  = 12;
   localparam int NUM_W    = 34;
   localparam int QUO_W    = 8;
   localparam int NUM_CELLS = QUO_W;

   localparam logic [23:0] BLACK_LIGHT = 24'hc0c0c0;
   localparam logic [23:0] BLACK_SHADE = 24'h606060;

   localparam logic [2:0] REG_COLOR_FROM   = 3'd0;
   localparam logic [2:0] REG_COLOR_TO     = 3'd1;
   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd2;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
   localparam logic [2:0] REG_PATTERN      = 3'd4;
   localparam logic [2:0] REG_EDGE_STYLE   = 3'd5;
   localparam logic [2:0] REG_FLIP         = 3'd6;

   localparam logic [1:0] PAT_SOLID = 2'd0;
   localparam logic [1:0] PAT_DIAG  = 2'd1;
   localparam logic [1:0] PAT_HORIZ = 2'd2;
   localparam logic [1:0] PAT_VERT  = 2'd3;

   localparam logic [1:0] STYLE_FLAT   = 2'd0;
   localparam logic [1:0] STYLE_BEVEL  = 2'd1;
   localparam logic [1:0] STYLE_BUTTON = 2'd2;

   localparam logic [1:0] EDGE_NONE  = 2'd0;
   localparam logic [1:0] EDGE_LIGHT = 2'd1;
   localparam logic [1:0] EDGE_DARK  = 2'd2;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } gbt_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       in_range;
   } gbt_rsp_type;

   typedef struct packed {
      logic [23:0]       color_from;
      logic [23:0]       color_to;
      logic [SIDE_W-1:0] image_width;
      logic [SIDE_W-1:0] image_height;
      logic [1:0]        pattern;
      logic [1:0]        edge_style;
      logic              flip;
   } gbt_cfg_type;

   // one item in flight through the divider chain, three color channels
   typedef struct packed {
      logic [2:0][NUM_W-1:0] rem;
      logic [NUM_W-1:0]      den;
      logic [2:0][QUO_W-1:0] quo;
      logic [2:0]            neg;
      logic [2:0][7:0]       base;
      logic [1:0]            kind;
      logic                  in_range;
   } gbt_div_type;

endpackage

[hdl/gbt_prep.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbt_prep
// coordinate capture, flip, edge class and gradient numerator/denominator
// ---------------------------------------------------------------------------
module gbt_prep import gbt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  gbt_cfg_type cfg,
   input  logic        req_valid,
   input  gbt_req_type req_data,
   output logic        prep_valid,
   output gbt_div_type prep_data
);

   logic [SIDE_W-1:0] w, h;

   // stage 0: input register
   logic               v0_ff, v0_in;
   logic [COORD_W-1:0] x0_ff, x0_in, y0_ff, y0_in;
   // stage 1: range and flip
   logic               v1_ff, v1_in, inr1_ff, inr1_in;
   logic [COORD_W-1:0] x1_ff, x1_in, y1_ff, y1_in;
   // stage 2: products and edge class
   logic               v2_ff, v2_in, inr2_ff, inr2_in;
   logic [COORD_W-1:0] x2_ff, x2_in, y2_ff, y2_in;
   logic [25:0]        xh2_ff, xh2_in, yw2_ff, yw2_in, wh2_ff, wh2_in;
   logic [1:0]         kind2_ff, kind2_in;
   // stage 3: selected numerator base and denominator
   logic               v3_ff, v3_in, inr3_ff, inr3_in;
   logic [25:0]        s3_ff, s3_in;
   logic [NUM_W-1:0]   den3_ff, den3_in;
   logic [1:0]         kind3_ff, kind3_in;
   logic [2:0][7:0]    mag3_ff, mag3_in, base3_ff, base3_in;
   logic [2:0]         neg3_ff, neg3_in;
   // stage 4: numerator magnitude
   logic               v4_ff, v4_in;
   gbt_div_type        d4_ff, d4_in;

   assign w = (cfg.image_width > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : cfg.image_width;
   assign h = (cfg.image_height > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : cfg.image_height;

   always_comb begin
      v0_in = req_valid;
      x0_in = req_data.col;
      y0_in = req_data.row;
   end

   always_comb begin
      logic [SIDE_W-1:0] fx, fy;
      fx = w - SIDE_W'(1) - {1'b0, x0_ff};
      fy = h - SIDE_W'(1) - {1'b0, y0_ff};
      v1_in   = v0_ff;
      inr1_in = ({1'b0, x0_ff} < w) && ({1'b0, y0_ff} < h);
      x1_in   = cfg.flip ? fx[COORD_W-1:0] : x0_ff;
      y1_in   = cfg.flip ? fy[COORD_W-1:0] : y0_ff;
   end

   always_comb begin
      logic [SIDE_W-1:0] lo, hx, hy, xe, ye;
      logic              on;
      v2_in   = v1_ff;
      inr2_in = inr1_ff;
      x2_in   = x1_ff;
      y2_in   = y1_ff;
      xh2_in  = 26'(x1_ff * h);
      yw2_in  = 26'(y1_ff * w);
      wh2_in  = 26'(w * h);
      xe = {1'b0, x1_ff};
      ye = {1'b0, y1_ff};
      on = 1'b0;
      lo = '0;
      hx = '0;
      hy = '0;
      if (cfg.edge_style == STYLE_BUTTON && h > SIDE_W'(2)) begin
         on = 1'b1;
         hx = w - SIDE_W'(1);
         hy = h - SIDE_W'(1);
      end else if (cfg.edge_style == STYLE_BEVEL && h > SIDE_W'(4) && w >= SIDE_W'(3)) begin
         on = 1'b1;
         lo = SIDE_W'(1);
         hx = w - SIDE_W'(2);
         hy = h - SIDE_W'(2);
      end
      kind2_in = EDGE_NONE;
      if (on && xe >= lo && xe <= hx && ye >= lo && ye <= hy) begin
         // columns win over rows, the dark column over the light one
         if (xe == hx)      kind2_in = EDGE_DARK;
         else if (xe == lo) kind2_in = EDGE_LIGHT;
         else if (ye == lo) kind2_in = EDGE_LIGHT;
         else if (ye == hy) kind2_in = EDGE_DARK;
      end
   end

   always_comb begin
      logic signed [8:0] d;
      v3_in    = v2_ff;
      inr3_in  = inr2_ff;
      kind3_in = kind2_ff;
      case (cfg.pattern)
         PAT_DIAG: begin
            s3_in   = xh2_ff + yw2_ff;
            den3_in = NUM_W'({wh2_ff, 1'b0}) << (QUO_W - 1);
         end
         PAT_HORIZ: begin
            s3_in   = 26'(x2_ff);
            den3_in = NUM_W'(w) << (QUO_W - 1);
         end
         PAT_VERT: begin
            s3_in   = 26'(y2_ff);
            den3_in = NUM_W'(h) << (QUO_W - 1);
         end
         default: begin
            s3_in   = '0;
            den3_in = NUM_W'(1) << (QUO_W - 1);
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         base3_in[i] = cfg.color_from[23-8*i -: 8];
         d = $signed({1'b0, cfg.color_to[23-8*i -: 8]}) - $signed({1'b0, base3_in[i]});
         neg3_in[i] = d[8];
         mag3_in[i] = d[8] ? 8'(-d) : d[7:0];
      end
   end

   always_comb begin
      v4_in = v3_ff;
      for (int i = 0; i < 3; i++) begin
         d4_in.rem[i] = NUM_W'(mag3_ff[i] * s3_ff);
         d4_in.quo[i] = '0;
      end
      d4_in.den      = den3_ff;
      d4_in.neg      = neg3_ff;
      d4_in.base     = base3_ff;
      d4_in.kind     = kind3_ff;
      d4_in.in_range = inr3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff    <= x0_in;
         y0_ff    <= y0_in;
         inr1_ff  <= inr1_in;
         x1_ff    <= x1_in;
         y1_ff    <= y1_in;
         inr2_ff  <= inr2_in;
         x2_ff    <= x2_in;
         y2_ff    <= y2_in;
         xh2_ff   <= xh2_in;
         yw2_ff   <= yw2_in;
         wh2_ff   <= wh2_in;
         kind2_ff <= kind2_in;
         inr3_ff  <= inr3_in;
         s3_ff    <= s3_in;
         den3_ff  <= den3_in;
         kind3_ff <= kind3_in;
         mag3_ff  <= mag3_in;
         base3_ff <= base3_in;
         neg3_ff  <= neg3_in;
         d4_ff    <= d4_in;
      end
   end

   assign prep_valid = v4_ff;
   assign prep_data  = d4_ff;

endmodule

[hdl/gbt_div_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbt_div_cell
// one restoring division step for three channels, quotient bit per cell
// ---------------------------------------------------------------------------
module gbt_div_cell import gbt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        cell_valid_in,
   input  gbt_div_type cell_data_in,
   output logic        cell_valid_out,
   output gbt_div_type cell_data_out
);

   logic        valid_ff, valid_in;
   gbt_div_type data_ff, data_in;

   always_comb begin
      logic ge;
      data_in  = cell_data_in;
      valid_in = cell_valid_in;
      for (int i = 0; i < 3; i++) begin
         ge = cell_data_in.rem[i] >= cell_data_in.den;
         data_in.rem[i] = ge ? cell_data_in.rem[i] - cell_data_in.den : cell_data_in.rem[i];
         data_in.quo[i] = {cell_data_in.quo[i][QUO_W-2:0], ge};
      end
      // divisor moves one place down for the next cell
      data_in.den = cell_data_in.den >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign cell_valid_out = valid_ff;
   assign cell_data_out  = data_ff;

endmodule

[hdl/gbt_finish.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gbt_finish
// floor correction, color offset, edge shading and output register
// ---------------------------------------------------------------------------
module gbt_finish import gbt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  gbt_cfg_type cfg,
   input  logic        fin_valid,
   input  gbt_div_type fin_data,
   output logic        rsp_valid,
   output gbt_rsp_type rsp_data
);

   logic        rsp_valid_ff, rsp_valid_in;
   gbt_rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      logic [2:0][7:0]   c;
      logic [8:0]        qq;
      logic signed [9:0] v;
      logic [9:0]        x3;
      logic              black;
      black = (cfg.pattern == PAT_SOLID) && (cfg.color_from == 24'd0);
      for (int i = 0; i < 3; i++) begin
         // floor for a negative numerator rounds away from zero
         qq = {1'b0, fin_data.quo[i]} +
              9'(fin_data.neg[i] && (fin_data.rem[i] != '0));
         if (fin_data.neg[i]) v = $signed({2'b0, fin_data.base[i]}) - $signed({1'b0, qq});
         else                 v = $signed({2'b0, fin_data.base[i]}) + $signed({1'b0, qq});
         if (v < 0)                 c[i] = 8'd0;
         else if (v > 10'sd255)     c[i] = 8'd255;
         else                       c[i] = v[7:0];
         x3 = {2'b0, c[i]} + {1'b0, c[i], 1'b0};
         if (fin_data.kind == EDGE_LIGHT) begin
            if (black)                 c[i] = BLACK_LIGHT[23-8*i -: 8];
            else if (x3[9:1] > 9'd255) c[i] = 8'd255;
            else                       c[i] = x3[8:1];
         end else if (fin_data.kind == EDGE_DARK) begin
            if (black) c[i] = BLACK_SHADE[23-8*i -: 8];
            else       c[i] = x3[9:2];
         end
         if (!fin_data.in_range) c[i] = 8'd0;
      end
      rsp_valid_in         = fin_valid;
      rsp_data_in.red      = c[0];
      rsp_data_in.green    = c[1];
      rsp_data_in.blue     = c[2];
      rsp_data_in.in_range = fin_data.in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/gradient_bevel_texture_pixel.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gradient_bevel_texture_pixel
// per-pixel color of a solid or linear gradient texture with bevel/button
// edges and optional 180 degree flip
//
//   channel   direction  handshake          payload
//   req       in         req_valid/stall    gbt_req_type (col, row)
//   rsp       out        rsp_valid/stall    gbt_rsp_type (red, green, blue, in_range)
//   csr       in         csr_write          csr_index, csr_data
//
// one pixel transfer per cycle unless stalled; stages: input register, four
// prep stages, a chain of 8 divider cells (one quotient bit each), output reg
// the pipeline moves as a whole; it holds only while the output register is
// full and stalled
// synchronous active-high reset clears valids and configuration registers,
// no clearing pass
// ---------------------------------------------------------------------------
module gradient_bevel_texture_pixel import gbt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  gbt_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output gbt_rsp_type rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   gbt_cfg_type cfg_ff, cfg_in;
   logic        adv;

   // chain taps between the divider cells
   logic        chain_valid [0:NUM_CELLS];
   gbt_div_type chain_data  [0:NUM_CELLS];

   // whole pipeline advances unless a finished pixel waits on a stall
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_COLOR_FROM:   cfg_in.color_from   = csr_data;
            REG_COLOR_TO:     cfg_in.color_to     = csr_data;
            REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_data[SIDE_W-1:0];
            REG_IMAGE_HEIGHT: cfg_in.image_height = csr_data[SIDE_W-1:0];
            REG_PATTERN:      cfg_in.pattern      = csr_data[1:0];
            REG_EDGE_STYLE:   cfg_in.edge_style   = csr_data[1:0];
            REG_FLIP:         cfg_in.flip         = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{color_from:   24'd0,
                     color_to:     24'd0,
                     image_width:  SIDE_W'(1),
                     image_height: SIDE_W'(1),
                     pattern:      PAT_SOLID,
                     edge_style:   STYLE_FLAT,
                     flip:         1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // coordinates to numerator and denominator
   gbt_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .prep_valid (chain_valid[0]),
      .prep_data  (chain_data[0])
   );

   // divider chain, msb of the quotient first
   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      gbt_div_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .adv            (adv),
         .cell_valid_in  (chain_valid[g]),
         .cell_data_in   (chain_data[g]),
         .cell_valid_out (chain_valid[g+1]),
         .cell_data_out  (chain_data[g+1])
      );
   end

   // color offset, shading, output register
   gbt_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .fin_valid (chain_valid[NUM_CELLS]),
      .fin_data  (chain_data[NUM_CELLS]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // out-of-range pixels carry black
   a_range_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.in_range |->
         rsp_data.red == 8'd0 && rsp_data.green == 8'd0 && rsp_data.blue == 8'd0)
      else $error("out-of-range pixel with nonzero color");

   // a pixel leaving the last cell lands in the output register
   a_chain_out: assert property (@(posedge clock) disable iff (reset)
      adv && chain_valid[NUM_CELLS] |=> rsp_valid)
      else $error("pixel lost between divider chain and output");

   // an empty output register never holds back the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output register");
`endif

endmodule
